[rtl/five_bit_letter_packer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the five-bit letter packer
// Shared concurrent assertion helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FIVE_BIT_LETTER_PACKER_DEFINES_SVH
`define FIVE_BIT_LETTER_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define FLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flp assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define FLP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flp assertion failed");

`else

`define FLP_ASSERT_IMP(label, ante, cons)
`define FLP_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/flp_pkg.sv]
// ----------------------------------------------------------------------------
// flp_pkg
// Types and constants shared by the five-bit letter packer modules.
// ----------------------------------------------------------------------------
package flp_pkg;

    localparam int ACC_W      = 12;
    localparam int HELD_W     = 4;
    localparam int COUNT_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [7:0]        LETTER_BASE = 8'd97;
    localparam logic [HELD_W-1:0] CODE_BITS   = 4'd5;
    localparam logic [HELD_W-1:0] BYTE_BITS   = 4'd8;

    localparam logic MODE_PACK   = 1'b0;
    localparam logic MODE_UNPACK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 2'd0,
        CFG_LETTER_COUNT = 2'd1
    } flp_cfg_idx_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } flp_result_t;

    // Up to two results produced by one item, first goes out first
    typedef struct packed {
        logic [1:0]  count;
        flp_result_t first;
        flp_result_t second;
    } flp_push_t;

endpackage

[rtl/flp_core.sv]
// ----------------------------------------------------------------------------
// flp_core
// Codec datapath: stream state, config registers, per-item result logic.
// ----------------------------------------------------------------------------
`include "five_bit_letter_packer_defines.svh"

module flp_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [flp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           fire,
    input  logic [7:0]                     item_data,
    input  logic                           item_last,
    output flp_pkg::flp_push_t             push
);
    import flp_pkg::*;

    function automatic logic [ACC_W-1:0] low_mask(input logic [HELD_W-1:0] n);
        return (ACC_W'(1) << n) - ACC_W'(1);
    endfunction

    logic                mode_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic [HELD_W-1:0]   held_reg,    held_next;
    logic [COUNT_W-1:0]  emitted_reg, emitted_next;

    // pack path
    logic [4:0]          pk_code;
    logic [ACC_W-1:0]    pk_acc, pk_rem_acc;
    logic [HELD_W-1:0]   pk_held, pk_sh, pk_rem_h;
    logic                pk_full;
    logic [7:0]          pk_byte, pk_pad;

    // unpack path
    logic                up_active, up_more, up_last0, up_last1, up_reached;
    logic [ACC_W-1:0]    up_acc, up_acc1, up_acc2;
    logic [HELD_W-1:0]   up_held, up_sh0, up_sh1;
    logic [4:0]          up_code0, up_code1;
    logic [COUNT_W-1:0]  up_e1, up_e2;

    flp_push_t           res;

    always_comb
    begin
        pk_code    = 5'(item_data - LETTER_BASE);
        pk_acc     = {acc_reg[ACC_W-6:0], pk_code};
        pk_held    = held_reg + CODE_BITS;
        pk_full    = (pk_held >= BYTE_BITS);
        pk_sh      = pk_held - BYTE_BITS;
        pk_byte    = 8'(pk_acc >> pk_sh);
        pk_rem_h   = pk_full ? pk_sh : pk_held;
        pk_rem_acc = pk_full ? (pk_acc & low_mask(pk_sh)) : pk_acc;
        pk_pad     = 8'(pk_rem_acc << (BYTE_BITS - pk_rem_h));

        up_active  = (emitted_reg < count_reg);
        up_acc     = {acc_reg[ACC_W-9:0], item_data};
        up_held    = held_reg + BYTE_BITS;
        up_sh0     = up_held - CODE_BITS;
        up_code0   = 5'(up_acc >> up_sh0);
        up_e1      = emitted_reg + COUNT_W'(1);
        up_last0   = (up_e1 == count_reg);
        up_acc1    = up_acc & low_mask(up_sh0);
        up_more    = (up_sh0 >= CODE_BITS) && !up_last0;
        up_sh1     = up_sh0 - CODE_BITS;
        up_code1   = 5'(up_acc1 >> up_sh1);
        up_e2      = up_e1 + COUNT_W'(1);
        up_last1   = (up_e2 == count_reg);
        up_acc2    = up_acc1 & low_mask(up_sh1);
        up_reached = up_more ? up_last1 : up_last0;

        res          = '0;
        acc_next     = acc_reg;
        held_next    = held_reg;
        emitted_next = emitted_reg;

        if (mode_reg == MODE_PACK)
        begin
            if (pk_full)
            begin
                res.count  = (item_last && pk_rem_h != '0) ? 2'd2 : 2'd1;
                res.first  = '{data: pk_byte, last: item_last && pk_rem_h == '0};
                res.second = '{data: pk_pad, last: 1'b1};
            end
            else
            begin
                res.count  = item_last ? 2'd1 : 2'd0;
                res.first  = '{data: pk_pad, last: 1'b1};
            end
            acc_next  = pk_rem_acc;
            held_next = pk_rem_h;
        end
        else if (up_active)
        begin
            res.count  = up_more ? 2'd2 : 2'd1;
            res.first  = '{data: LETTER_BASE + {3'b000, up_code0}, last: up_last0};
            res.second = '{data: LETTER_BASE + {3'b000, up_code1}, last: up_last1};
            emitted_next = up_more ? up_e2 : up_e1;
            if (up_reached)
            begin
                acc_next  = '0;
                held_next = '0;
            end
            else
            begin
                acc_next  = up_more ? up_acc2 : up_acc1;
                held_next = up_more ? (up_sh1) : up_sh0;
            end
        end

        // end of stream: start clean
        if (item_last)
        begin
            acc_next     = '0;
            held_next    = '0;
            emitted_next = '0;
        end

        push       = res;
        push.count = fire ? res.count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PACK;
            count_reg   <= '0;
            acc_reg     <= '0;
            held_reg    <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:
                    begin
                        mode_reg    <= cfg_data[0];
                        acc_reg     <= '0;
                        held_reg    <= '0;
                        emitted_reg <= '0;
                    end
                    CFG_LETTER_COUNT:
                    begin
                        count_reg <= cfg_data;
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end
            else if (fire)
            begin
                acc_reg     <= acc_next;
                held_reg    <= held_next;
                emitted_reg <= emitted_next;
            end
        end
    end

    `FLP_ASSERT_IMP(a_pack_held_lt_byte, mode_reg == MODE_PACK, held_reg < BYTE_BITS)
    `FLP_ASSERT_IMP(a_unpack_held_lt_code, mode_reg == MODE_UNPACK, held_reg < CODE_BITS)
    `FLP_ASSERT_IMP(a_pack_last_flushes, fire && item_last && mode_reg == MODE_PACK, push.count != 2'd0)

endmodule

[rtl/flp_out_fifo.sv]
// ----------------------------------------------------------------------------
// flp_out_fifo
// Result queue: takes up to two results a cycle, delivers one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "five_bit_letter_packer_defines.svh"

module flp_out_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  flp_pkg::flp_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         data_out,
    output logic               last_out
);
    import flp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    flp_result_t        mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_second;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid     = (count_reg != '0);
    assign pop           = out_valid && !out_stall;
    assign room          = (count_reg <= CNT_W'(DEPTH - 2));
    assign data_out      = mem[rd_ptr_reg].data;
    assign last_out      = mem[rd_ptr_reg].last;
    assign wr_ptr_second = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        unique case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_second;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_second);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    `FLP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `FLP_ASSERT_IMP(a_no_overflow, push.count != 2'd0, (32'(count_reg) + 32'(push.count)) <= DEPTH)
    `FLP_ASSERT_NXT(a_pop_drains, pop && push.count == 2'd0, count_reg == CNT_W'($past(count_reg) - 1'b1))

endmodule

[rtl/five_bit_letter_packer.sv]
// ----------------------------------------------------------------------------
// five_bit_letter_packer
// Lowercase text codec at five bits per letter, pack and unpack modes.
// ----------------------------------------------------------------------------
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------
//   input     | in_valid / in_stall    | data_in, last_in
//   output    | out_valid / out_stall  | data_out, last_out
//   config    | cfg_we (no wait)       | cfg_index, cfg_data
//
// One input transfer per cycle enters the input register while in_stall is low;
// the codec step runs combinationally from that register into the result queue,
// so a result passes the input register and then the queue before it leaves.
// An item that makes two results pushes both at once; the queue drains one per
// cycle while out_stall is low, so a run of such items stalls the input while it drains.
// Input stalls only while the result queue lacks room for two results.
// Reset clears the stream state, both config registers and the queue.
// Writing the mode register clears the stream state; write config only idle.
//
module five_bit_letter_packer
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [flp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_in,
    input  logic                           last_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     data_out,
    output logic                           last_out
);
    import flp_pkg::*;

    // Input register: holds one accepted item until the codec step runs
    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       s1_fire;
    logic       in_take;
    logic       room;
    flp_push_t  push;

    // Advance the held item once the queue can take its results
    assign s1_fire  = s1_valid_reg && room;
    // Hold off new transfers only while a held item cannot advance
    assign in_stall = s1_valid_reg && !room;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset: only looked at while s1_valid_reg is set
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_in;
            s1_last_reg <= last_in;
        end
    end

    // Codec step: stream state, config, and up to two results per item
    flp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (s1_fire),
        .item_data (s1_data_reg),
        .item_last (s1_last_reg),
        .push      (push)
    );

    // Result queue: the registered output side
    flp_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last_out  (last_out)
    );

endmodule
